FILE: sv/hcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_pkg
// Shared widths, constants and types of the hexagon cell locator.
// ----------------------------------------------------------------------------
package hcl_pkg;

  localparam int COORD_W    = 32;
  localparam int SQRT3_FB   = 24;
  localparam int SQRT3_Q    = 29058991;
  localparam int SQRT3_W    = 25;
  localparam int NUM_W      = 60;
  localparam int QUO_W      = 32;
  localparam int DIV_STAGES = QUO_W;
  localparam int TRY_W      = NUM_W + QUO_W + 1;
  localparam int D1_W       = 34;
  localparam int IDX_W      = QUO_W + 1;
  localparam int CST_W      = NUM_W + 2;

  localparam logic [D1_W-1:0]  D1_RESET = D1_W'(3 * 65536);
  localparam logic [NUM_W-1:0] N_RESET  = NUM_W'(64'(3) * 64'(SQRT3_Q) * 64'(65536));
  localparam logic [SQRT3_W:0] SQRT3_S  = (SQRT3_W + 1)'(SQRT3_Q);

  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] mag;
  } div_req_t;

endpackage

FILE: sv/hcl_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_req_if
// Point request channel: valid/ready with the point coordinates.
// ----------------------------------------------------------------------------
interface hcl_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

FILE: sv/hcl_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_rsp_if
// Result channel: valid/ready with the axial hexagon indices.
// ----------------------------------------------------------------------------
interface hcl_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] hex_i;
  logic signed [31:0] hex_j;

  modport source (output valid, output hex_i, output hex_j, input ready);
  modport sink   (input valid, input hex_i, input hex_j, output ready);
endinterface

FILE: sv/hcl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_div
// Pipelined restoring divider of a magnitude, one quotient bit per stage.
// ----------------------------------------------------------------------------
module hcl_div
  import hcl_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  div_req_t         req,
  input  logic [NUM_W-1:0] divisor,
  output logic [QUO_W-1:0] quo,
  output logic [NUM_W-1:0] rem,
  output logic             neg
);

  logic [NUM_W-1:0] rem_r [DIV_STAGES];
  logic [QUO_W-1:0] quo_r [DIV_STAGES];
  logic             neg_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [NUM_W-1:0] src;
    logic [QUO_W-1:0] qsrc;
    logic             nsrc;
    logic [TRY_W-1:0] shifted;
    logic [TRY_W-1:0] diff;
    logic [NUM_W-1:0] rem_nxt;
    logic [QUO_W-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign src  = req.mag;
      assign qsrc = '0;
      assign nsrc = req.neg;
    end else begin : g_next
      assign src  = rem_r[k-1];
      assign qsrc = quo_r[k-1];
      assign nsrc = neg_r[k-1];
    end

    // trial subtract of the divisor at this bit weight
    always_comb begin
      shifted = TRY_W'(divisor) << (QUO_W - 1 - k);
      diff    = TRY_W'(src) - shifted;
      rem_nxt = src;
      quo_nxt = qsrc;
      if (!diff[TRY_W-1]) begin
        rem_nxt = diff[NUM_W-1:0];
        quo_nxt[QUO_W-1-k] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        quo_r[k] <= quo_nxt;
        neg_r[k] <= nsrc;
      end
    end
  end

  assign quo = quo_r[DIV_STAGES-1];
  assign rem = rem_r[DIV_STAGES-1];
  assign neg = neg_r[DIV_STAGES-1];

endmodule

FILE: sv/hex_cell_locate_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_cell_locate_top
// Nearest flat-top hexagon (axial indices) for a signed Q16.16 point.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : point request (x_coord, y_coord), valid/ready.
//   out_rsp : result (hex_i, hex_j), valid/ready, one per request.
//   cfg_we / cfg_wdata : hexagon radius write; a zero radius acts as 1 (one LSB).
//     Write only while the block is idle; the derived divisors are
//     registered at the write.
// Pipeline: from request accept to result valid, two input stages, 32
//   divider stages, floor fix, multiply, cost, select.
// Throughput: one request per cycle unless the output stalls. The two 32-stage
//   restoring dividers (one quotient bit per stage) set the depth, not the rate.
// Reset: all valid bits clear; the radius returns to 1.0 (65536).
// Stall: when the output holds a result that is not taken, the whole
//   pipeline holds; in_req.ready drops and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module hex_cell_locate_top
  import hcl_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  hcl_req_if.sink       in_req,
  hcl_rsp_if.source     out_rsp,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata
);

  // advance the whole pipe when the output slot is free or its result is taken
  logic adv;
  logic out_valid_r;
  assign adv          = !out_valid_r || out_rsp.ready;
  assign in_req.ready = adv;

  // radius-derived divisors: 3R and 3*sqrt3q*R
  logic [D1_W-1:0]  d1_r;
  logic [NUM_W-1:0] n_r;
  logic [31:0]      rz;
  assign rz = (cfg_wdata == '0) ? 32'd1 : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r <= D1_RESET;
      n_r  <= N_RESET;
    end else if (cfg_we) begin
      d1_r <= D1_W'({rz, 1'b0}) + D1_W'(rz);
      n_r  <= NUM_W'(rz) * NUM_W'(3 * SQRT3_Q);
    end
  end

  // stage 1: 2X, 3*Y*2^24 and sqrt3q*X
  logic                    v1_r;
  logic signed [IDX_W-1:0] x2_r;
  logic signed [NUM_W-1:0] py_r;
  logic signed [NUM_W-1:0] qx_r;
  logic signed [NUM_W-1:0] ye;

  assign ye = NUM_W'(in_req.y_coord);

  always_ff @(posedge clk) begin
    if (adv) begin
      x2_r <= {in_req.x_coord, 1'b0};
      py_r <= (ye <<< (SQRT3_FB + 1)) + (ye <<< SQRT3_FB);
      qx_r <= NUM_W'(in_req.x_coord) * NUM_W'($signed(SQRT3_S));
    end
  end

  // stage 2: sum and split into sign and magnitude
  logic                    v2_r;
  div_req_t                ri_r;
  div_req_t                rj_r;
  logic signed [NUM_W-1:0] sj;

  assign sj = py_r + qx_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ri_r.neg <= x2_r[IDX_W-1];
      ri_r.mag <= NUM_W'(x2_r[IDX_W-1] ? -x2_r : x2_r) & NUM_W'({IDX_W{1'b1}});
      rj_r.neg <= sj[NUM_W-1];
      rj_r.mag <= sj[NUM_W-1] ? -sj : sj;
    end
  end

  // dividers
  logic [QUO_W-1:0] qi, qj;
  logic [NUM_W-1:0] remi, remj;
  logic             negi, negj;

  hcl_div u_div_i (
    .clk     (clk),
    .en      (adv),
    .req     (ri_r),
    .divisor (NUM_W'(d1_r)),
    .quo     (qi),
    .rem     (remi),
    .neg     (negi)
  );

  hcl_div u_div_j (
    .clk     (clk),
    .en      (adv),
    .req     (rj_r),
    .divisor (n_r),
    .quo     (qj),
    .rem     (remj),
    .neg     (negj)
  );

  logic vd_r [DIV_STAGES];

  // floor fix: negative with a remainder steps down one and flips the remainder
  logic                    vf_r;
  logic signed [IDX_W-1:0] i0f_r, j0f_r;
  logic [D1_W-1:0]         uf_r;
  logic [NUM_W-1:0]        bf_r;
  logic                    fi, fj;

  assign fi = negi && (remi != '0);
  assign fj = negj && (remj != '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      i0f_r <= !negi ? IDX_W'(qi) : (fi ? ~IDX_W'(qi) : -IDX_W'(qi));
      j0f_r <= !negj ? IDX_W'(qj) : (fj ? ~IDX_W'(qj) : -IDX_W'(qj));
      uf_r  <= fi ? d1_r - remi[D1_W-1:0] : remi[D1_W-1:0];
      bf_r  <= fj ? n_r - remj : remj;
    end
  end

  // multiply: A = u * sqrt3q
  logic                    vm_r;
  logic signed [IDX_W-1:0] i0m_r, j0m_r;
  logic [NUM_W-1:0]        am_r, bm_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      i0m_r <= i0f_r;
      j0m_r <= j0f_r;
      am_r  <= NUM_W'(uf_r) * NUM_W'(SQRT3_Q);
      bm_r  <= bf_r;
    end
  end

  // candidate costs relative to the floor corner
  logic                    vc_r;
  logic signed [IDX_W-1:0] i0c_r, j0c_r;
  logic signed [CST_W-1:0] c01_r, c10_r, c11_r;
  logic signed [CST_W-1:0] ne, ae, be;

  assign ne = CST_W'(n_r);
  assign ae = CST_W'(am_r);
  assign be = CST_W'(bm_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      i0c_r <= i0m_r;
      j0c_r <= j0m_r;
      c01_r <= ne + ae - (be <<< 1);
      c10_r <= ne - (ae <<< 1) + be;
      c11_r <= ne - ae - be;
    end
  end

  // select the strictly cheaper candidate, keep the earlier on a tie
  logic                    bi, bj;
  logic signed [CST_W-1:0] best;
  logic signed [IDX_W:0]   si, sj2;
  logic signed [31:0]      hi_nxt, hj_nxt;
  logic signed [31:0]      hi_r, hj_r;

  function automatic logic signed [31:0] sat32(input logic signed [IDX_W:0] v);
    logic signed [IDX_W:0] maxv;
    logic signed [IDX_W:0] minv;
    maxv = (IDX_W + 1)'(32'sh7FFF_FFFF);
    minv = (IDX_W + 1)'(-34'sd2147483648);
    if (v > maxv) return 32'sh7FFF_FFFF;
    if (v < minv) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  always_comb begin
    best = '0;
    bi   = 1'b0;
    bj   = 1'b0;
    if (c01_r < best) begin
      best = c01_r;
      bi   = 1'b0;
      bj   = 1'b1;
    end
    if (c10_r < best) begin
      best = c10_r;
      bi   = 1'b1;
      bj   = 1'b0;
    end
    if (c11_r < best) begin
      bi = 1'b1;
      bj = 1'b1;
    end
    si     = (IDX_W + 1)'(i0c_r) + (IDX_W + 1)'({1'b0, bi});
    sj2    = (IDX_W + 1)'(j0c_r) + (IDX_W + 1)'({1'b0, bj});
    hi_nxt = sat32(si);
    hj_nxt = sat32(sj2);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hi_r <= hi_nxt;
      hj_r <= hj_nxt;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      vf_r        <= 1'b0;
      vm_r        <= 1'b0;
      vc_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < DIV_STAGES; k++) vd_r[k] <= 1'b0;
    end else if (adv) begin
      v1_r    <= in_req.valid;
      v2_r    <= v1_r;
      vd_r[0] <= v2_r;
      for (int k = 1; k < DIV_STAGES; k++) vd_r[k] <= vd_r[k-1];
      vf_r        <= vd_r[DIV_STAGES-1];
      vm_r        <= vf_r;
      vc_r        <= vm_r;
      out_valid_r <= vc_r;
    end
  end

  assign out_rsp.valid = out_valid_r;
  assign out_rsp.hex_i = hi_r;
  assign out_rsp.hex_j = hj_r;

endmodule
